@@ rtl/assert_macros.svh @@
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the transform engine checkers.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ rtl/m4te_pkg.sv @@
// ============================================================================
// m4te_pkg
// Types and constants for the 4x4 fixed-point transform engine.
// ============================================================================
package m4te_pkg;

   localparam int DIM       = 4;          // active matrix dimension, 2..4
   localparam int MAX_DIM   = 4;          // storage dimension
   localparam int FRAC_BITS = 16;         // Q16.16
   localparam int COEFF_W   = 32;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int MAT_N     = MAX_DIM * MAX_DIM;
   localparam int PROD_W    = 2 * COEFF_W;
   localparam int ACC_W     = PROD_W + $clog2(MAX_DIM);
   localparam int HI_W      = ACC_W - COEFF_W + 1;   // bits that must agree for no saturation

   localparam logic [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
   localparam logic [COEFF_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_WR_CUR  = 2'd0,
      OP_WR_OPD  = 2'd1,
      OP_COMPOSE = 2'd2,
      OP_XFORM   = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [1:0]          row;
      logic [1:0]          col;
      logic signed [31:0]  coeff;
      logic signed [31:0]  vec_x;
      logic signed [31:0]  vec_y;
      logic signed [31:0]  vec_z;
      logic signed [31:0]  vec_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  out_x;
      logic signed [31:0]  out_y;
      logic signed [31:0]  out_z;
      logic signed [31:0]  out_w;
      logic                overflow;
   } rsp_type;

   // Control that rides along with each multiply through the MAC pipe.
   typedef struct packed {
      logic              vld;
      logic              first;     // first term of a dot product
      logic              last_dot;  // last term of a dot product
      logic              last_row;  // last dot product of a matrix row
      logic              last_all;  // last dot product of the transaction
      logic              compose;
      logic [IDX_W-1:0]  dst;       // result slot
      logic [IDX_W-1:0]  row;       // current-matrix row
   } tag_type;

   // Finished dot product handed back by the MAC.
   typedef struct packed {
      logic                vld;
      logic                sat;
      logic [COEFF_W-1:0]  value;
      logic                last_row;
      logic                last_all;
      logic                compose;
      logic [IDX_W-1:0]    dst;
      logic [IDX_W-1:0]    row;
   } wb_type;

endpackage

@@ rtl/m4te_mac.sv @@
// ============================================================================
// m4te_mac
// Shared multiply-accumulate unit: multiply, full-width accumulate, shift
// back by FRAC_BITS and saturate. One term per cycle, three stages.
// ============================================================================
module m4te_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [m4te_pkg::COEFF_W-1:0]  a,
   input  logic signed [m4te_pkg::COEFF_W-1:0]  b,
   input  m4te_pkg::tag_type                    tag,
   output m4te_pkg::wb_type                     wb
);

   m4te_pkg::tag_type                       s1_tag_ff, s2_tag_ff;
   logic signed [m4te_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic signed [m4te_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic signed [m4te_pkg::ACC_W-1:0]       shifted;
   logic [m4te_pkg::HI_W-1:0]               hi_bits;
   logic                                    in_range;
   m4te_pkg::wb_type                        wb_ff, wb_in;

   assign prod_in = a * b;

   // Exact sum: partial products extended, never truncated.
   assign acc_in = s1_tag_ff.first ? m4te_pkg::ACC_W'(prod_ff)
                                   : acc_ff + m4te_pkg::ACC_W'(prod_ff);

   assign shifted  = acc_ff >>> m4te_pkg::FRAC_BITS;
   assign hi_bits  = shifted[m4te_pkg::ACC_W-1:m4te_pkg::COEFF_W-1];
   assign in_range = (hi_bits == '0) || (hi_bits == '1);

   always_comb begin
      wb_in          = '0;
      wb_in.vld      = s2_tag_ff.vld && s2_tag_ff.last_dot;
      wb_in.sat      = !in_range;
      wb_in.last_row = s2_tag_ff.last_row;
      wb_in.last_all = s2_tag_ff.last_all;
      wb_in.compose  = s2_tag_ff.compose;
      wb_in.dst      = s2_tag_ff.dst;
      wb_in.row      = s2_tag_ff.row;
      if (in_range) begin
         wb_in.value = shifted[m4te_pkg::COEFF_W-1:0];
      end else if (acc_ff[m4te_pkg::ACC_W-1]) begin
         wb_in.value = m4te_pkg::COEFF_MIN;
      end else begin
         wb_in.value = m4te_pkg::COEFF_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         wb_ff     <= '0;
      end else begin
         s1_tag_ff <= tag;
         s2_tag_ff <= s1_tag_ff;
         wb_ff     <= wb_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s1_tag_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign wb = wb_ff;

endmodule

@@ rtl/matrix4_transform_engine.sv @@
// ============================================================================
// matrix4_transform_engine
// 4x4 homogeneous matrix transform engine, signed Q16.16 fixed point.
// ============================================================================
// Usage:
//  - req_* channel (valid/ready) carries one transaction: write a coefficient
//    of the current matrix, write a coefficient of the operand matrix,
//    compose (current := current x operand) or transform a vector.
//  - rsp_* channel (valid/ready) returns one transaction per compose or
//    transform. Compose returns zero components plus the overflow flag.
//  - Coefficient writes return nothing; out-of-range row/col writes are
//    dropped.
//  - All dot products run through one shared multiplier-accumulator at one
//    term per cycle. Transform: DIM*DIM terms. Compose: DIM^3 terms.
//    req_ready stays low while they run.
//  - Sums are exact; the total is shifted right by FRAC_BITS (floor) and
//    saturated to 32 bits, setting overflow.
//  - Result sits in an output register: a stalled receiver does not block
//    the next request from being taken; only the next result waits for it.
//  - Synchronous reset clears both matrices to zero and drops rsp_valid.
// ============================================================================
module matrix4_transform_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  m4te_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output m4te_pkg::rsp_type  rsp_data
);

   localparam int IW = m4te_pkg::IDX_W;
   localparam int CW = m4te_pkg::COEFF_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,   // feeding terms into the MAC
      ST_DRAIN  = 4'b0100,   // waiting for the MAC pipe to empty
      ST_FINISH = 4'b1000    // loading the output register
   } state_type;

   state_type                 state_ff, state_in;

   // Matrix storage, row-major, index {row, col}.
   logic signed [CW-1:0]      cur_ff [m4te_pkg::MAT_N];
   logic signed [CW-1:0]      opd_ff [m4te_pkg::MAT_N];
   logic signed [CW-1:0]      vec_ff [m4te_pkg::MAX_DIM];
   logic signed [CW-1:0]      res_ff [m4te_pkg::MAX_DIM];  // row buffer / result
   logic                      ovf_ff;
   logic                      compose_ff;

   // Loop counters: i = row, j = column (compose only), k = term.
   logic [IW-1:0]             i_ff, j_ff, k_ff;
   logic [IW-1:0]             j_max;
   logic                      k_last, j_last, i_last;

   // Row write-back and completion, in the cycle after the MAC result.
   logic                      rowwb_ff;
   logic [IW-1:0]             rowwb_row_ff;
   logic                      done_ff;

   logic                      rsp_valid_ff;
   m4te_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   logic                      rsp_load;

   logic                      req_take;
   logic                      wr_in_range;

   logic signed [CW-1:0]      mac_a, mac_b;
   m4te_pkg::tag_type         mac_tag;
   m4te_pkg::wb_type          mac_wb;

   localparam logic [IW-1:0] LAST_IDX = IW'(m4te_pkg::DIM - 1);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   assign wr_in_range = ({1'b0, req_data.row} < (IW+1)'(m4te_pkg::DIM))
                     && ({1'b0, req_data.col} < (IW+1)'(m4te_pkg::DIM));

   assign j_max  = compose_ff ? LAST_IDX : '0;
   assign k_last = (k_ff == LAST_IDX);
   assign j_last = (j_ff == j_max);
   assign i_last = (i_ff == LAST_IDX);

   // ---- operand selection for the shared MAC ----
   assign mac_a = cur_ff[{i_ff, k_ff}];
   assign mac_b = compose_ff ? opd_ff[{k_ff, j_ff}] : vec_ff[k_ff];

   always_comb begin
      mac_tag          = '0;
      mac_tag.vld      = (state_ff == ST_ISSUE);
      mac_tag.first    = (k_ff == '0);
      mac_tag.last_dot = k_last;
      mac_tag.last_row = k_last && j_last;
      mac_tag.last_all = k_last && j_last && i_last;
      mac_tag.compose  = compose_ff;
      mac_tag.dst      = compose_ff ? j_ff : i_ff;
      mac_tag.row      = i_ff;
   end

   m4te_mac u_mac (
      .clock (clock),
      .reset (reset),
      .a     (mac_a),
      .b     (mac_b),
      .tag   (mac_tag),
      .wb    (mac_wb)
   );

   // ---- sequencer ----
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_data.op == m4te_pkg::OP_COMPOSE
                          || req_data.op == m4te_pkg::OP_XFORM)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (k_last && j_last && i_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE) begin
            i_ff <= '0;
            j_ff <= '0;
            k_ff <= '0;
         end else if (state_ff == ST_ISSUE) begin
            if (k_last) begin
               k_ff <= '0;
               if (j_last) begin
                  j_ff <= '0;
                  i_ff <= i_ff + 1'b1;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end else begin
               k_ff <= k_ff + 1'b1;
            end
         end
      end
   end

   // ---- matrix storage: coefficient writes and compose row write-back ----
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < m4te_pkg::MAT_N; n++) begin
            cur_ff[n] <= '0;
            opd_ff[n] <= '0;
         end
      end else begin
         if (req_take && wr_in_range) begin
            if (req_data.op == m4te_pkg::OP_WR_CUR) begin
               cur_ff[{req_data.row, req_data.col}] <= req_data.coeff;
            end else if (req_data.op == m4te_pkg::OP_WR_OPD) begin
               opd_ff[{req_data.row, req_data.col}] <= req_data.coeff;
            end
         end
         // Row i is rewritten only after all its terms have been read.
         if (rowwb_ff) begin
            for (int c = 0; c < m4te_pkg::DIM; c++) begin
               cur_ff[{rowwb_row_ff, IW'(c)}] <= res_ff[c];
            end
         end
      end
   end

   // ---- per-transaction working registers ----
   always_ff @(posedge clock) begin
      if (req_take) begin
         compose_ff <= (req_data.op == m4te_pkg::OP_COMPOSE);
         vec_ff[0]  <= req_data.vec_x;
         vec_ff[1]  <= req_data.vec_y;
         vec_ff[2]  <= req_data.vec_z;
         vec_ff[3]  <= req_data.vec_w;
         ovf_ff     <= 1'b0;
         for (int c = 0; c < m4te_pkg::MAX_DIM; c++) begin
            res_ff[c] <= '0;
         end
      end else if (mac_wb.vld) begin
         res_ff[mac_wb.dst] <= mac_wb.value;
         ovf_ff             <= ovf_ff | mac_wb.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rowwb_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         rowwb_ff <= mac_wb.vld && mac_wb.compose && mac_wb.last_row;
         done_ff  <= mac_wb.vld && mac_wb.last_all;
      end
   end

   always_ff @(posedge clock) begin
      rowwb_row_ff <= mac_wb.row;
   end

   // ---- output register ----
   always_comb begin
      rsp_data_in          = '0;
      rsp_data_in.overflow = ovf_ff;
      if (!compose_ff) begin
         rsp_data_in.out_x = res_ff[0];
         rsp_data_in.out_y = res_ff[1];
         rsp_data_in.out_z = res_ff[2];
         rsp_data_in.out_w = res_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/m4te_checker.sv @@
// ============================================================================
// m4te_checker
// Port-level checks for the transform engine, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module m4te_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input m4te_pkg::req_type  req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input m4te_pkg::rsp_type  rsp_data
);

   logic take_wr;
   logic take_calc;

   assign take_wr   = req_valid && req_ready
                   && (req_data.op == m4te_pkg::OP_WR_CUR
                    || req_data.op == m4te_pkg::OP_WR_OPD);
   assign take_calc = req_valid && req_ready
                   && (req_data.op == m4te_pkg::OP_COMPOSE
                    || req_data.op == m4te_pkg::OP_XFORM);

   // Out of reset: idle, nothing pending.
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_ready && !rsp_valid)

   // Held response does not change.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Coefficient writes leave the engine ready for the next request.
   `ASSERT_NEXT(a_wr_single, clock, reset, take_wr, req_ready)

   // Compose and transform occupy the engine.
   `ASSERT_NEXT(a_calc_busy, clock, reset, take_calc, !req_ready)

   // No response can appear right after a compute transaction is taken.
   `ASSERT_NEXT(a_calc_no_early, clock, reset, take_calc, !$rose(rsp_valid))

endmodule

bind matrix4_transform_engine m4te_checker u_m4te_checker (.*);
